FILE: hw/rtl/rbst_pkg.sv
// Package for the ray/box slab test: widths, control words and the microprogram.
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Division loop count: one quotient bit per step.
  localparam int CNT_W = $clog2(WORD_WIDTH);
  localparam int UPC_W = 4;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  // Control word fields that drive the datapath.
  typedef struct packed {
    logic in_ready;
    logic first_load;
    logic div_init;
    logic div_pre;
    logic par_test;
    logic div_step;
    logic div_fix;
    logic order;
    logic narrow;
    logic empty_test;
    logic out_load;
  } ctl_t;

  // Status the sequencer tests for its jumps.
  typedef struct packed {
    logic in_valid;
    logic missed;
    logic dir_zero;
    logic last;
    logic out_busy;
  } stat_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_VALID,
    C_MISSED,
    C_DIR_ZERO,
    C_CNT_NZ,
    C_NOT_LAST,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    ctl_t             ctl;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] UA_WAIT   = 4'd0;
  localparam logic [UPC_W-1:0] UA_LOAD   = 4'd1;
  localparam logic [UPC_W-1:0] UA_SKIP   = 4'd2;
  localparam logic [UPC_W-1:0] UA_PAR    = 4'd3;
  localparam logic [UPC_W-1:0] UA_DIV    = 4'd4;
  localparam logic [UPC_W-1:0] UA_FIX    = 4'd5;
  localparam logic [UPC_W-1:0] UA_ORDER  = 4'd6;
  localparam logic [UPC_W-1:0] UA_NARROW = 4'd7;
  localparam logic [UPC_W-1:0] UA_EMPTY  = 4'd8;
  localparam logic [UPC_W-1:0] UA_EMIT   = 4'd9;
  localparam logic [UPC_W-1:0] UA_OUT    = 4'd10;
  localparam logic [UPC_W-1:0] UA_RET    = 4'd11;

  // Control store: jump to target when the condition holds, else step on.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t u;
    u = '0;
    u.cond   = C_NEVER;
    u.target = UA_WAIT;
    unique case (addr)
      UA_WAIT: begin
        u.ctl.in_ready = 1'b1;
        u.cond         = C_NO_VALID;
        u.target       = UA_WAIT;
      end
      UA_LOAD: begin
        u.ctl.first_load = 1'b1;
        u.ctl.div_init   = 1'b1;
      end
      UA_SKIP: begin
        u.ctl.div_pre = 1'b1;
        u.cond        = C_MISSED;
        u.target      = UA_EMIT;
      end
      UA_PAR: begin
        u.ctl.par_test = 1'b1;
        u.cond         = C_DIR_ZERO;
        u.target       = UA_EMIT;
      end
      UA_DIV: begin
        u.ctl.div_step = 1'b1;
        u.cond         = C_CNT_NZ;
        u.target       = UA_DIV;
      end
      UA_FIX:    u.ctl.div_fix    = 1'b1;
      UA_ORDER:  u.ctl.order      = 1'b1;
      UA_NARROW: u.ctl.narrow     = 1'b1;
      UA_EMPTY:  u.ctl.empty_test = 1'b1;
      UA_EMIT: begin
        u.cond   = C_NOT_LAST;
        u.target = UA_WAIT;
      end
      UA_OUT: begin
        u.ctl.out_load = 1'b1;
        u.cond         = C_OUT_BUSY;
        u.target       = UA_OUT;
      end
      UA_RET: begin
        u.cond   = C_ALWAYS;
        u.target = UA_WAIT;
      end
      default: begin
        u.cond   = C_ALWAYS;
        u.target = UA_WAIT;
      end
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rbst_in_if.sv
// Input channel: one axis of a ray/box query per word.
`timescale 1ns / 1ps
`default_nettype none
interface rbst_in_if;
  logic                  valid;
  logic                  ready;
  logic                  first_axis;
  logic                  last_axis;
  rbst_pkg::word_t       ray_origin;
  rbst_pkg::word_t       ray_direction;
  rbst_pkg::word_t       box_low;
  rbst_pkg::word_t       box_high;
  rbst_pkg::word_t       t_start;
  rbst_pkg::word_t       t_end;

  modport source (
    output valid, first_axis, last_axis, ray_origin, ray_direction,
           box_low, box_high, t_start, t_end,
    input  ready
  );
  modport sink (
    input  valid, first_axis, last_axis, ray_origin, ray_direction,
           box_low, box_high, t_start, t_end,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/rbst_out_if.sv
// Result channel: hit flag of one query per word.
`timescale 1ns / 1ps
`default_nettype none
interface rbst_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rbst_div_lane.sv
// One restoring divider lane: ((bound - origin) << FRAC_BITS) / dir, saturated.
`timescale 1ns / 1ps
`default_nettype none
module rbst_div_lane (
  input  logic            clk_i,
  input  logic            init_i,
  input  logic            pre_i,
  input  logic            step_i,
  input  logic            fix_i,
  input  rbst_pkg::word_t bound_i,
  input  rbst_pkg::word_t origin_i,
  input  rbst_pkg::word_t dir_i,
  output rbst_pkg::word_t quot_o
);
  import rbst_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = W + 1 + F;
  localparam int HW = F + 1;
  localparam int MW = (HW > W) ? HW : W;

  logic [W:0]    mag_q;
  logic [W-1:0]  den_q;
  logic          neg_q;
  logic          ovf_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  low_q;
  logic [W-1:0]  quo_q;
  word_t         res_q;

  logic signed [W:0] diff;
  logic [W:0]        mag_d;
  logic [W-1:0]      den_d;
  logic [DW-1:0]     dvd;
  logic [MW-1:0]     hi_ext;
  logic [W:0]        rs;
  logic [W:0]        sub;
  logic              ge;
  logic [W-1:0]      cap;
  logic [W-1:0]      qsat;

  always_comb begin
    diff   = {bound_i[W-1], bound_i} - {origin_i[W-1], origin_i};
    mag_d  = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
    den_d  = dir_i[W-1] ? W'(-dir_i) : W'(dir_i);
    dvd    = {mag_q, {F{1'b0}}};
    hi_ext = MW'(dvd[DW-1:W]);
    rs     = {rem_q, low_q[W-1]};
    sub    = rs - {1'b0, den_q};
    ge     = rs >= {1'b0, den_q};
    cap    = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    qsat   = (ovf_q || (quo_q > cap)) ? cap : quo_q;
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      mag_q <= mag_d;
      den_q <= den_d;
      neg_q <= diff[W] ^ dir_i[W-1];
    end
    if (pre_i) begin
      // quotient overflows the word when the top part already reaches the divisor
      ovf_q <= hi_ext >= MW'(den_q);
      rem_q <= hi_ext[W-1:0];
      low_q <= dvd[W-1:0];
      quo_q <= '0;
    end
    if (step_i) begin
      rem_q <= ge ? sub[W-1:0] : rs[W-1:0];
      low_q <= {low_q[W-2:0], 1'b0};
      quo_q <= {quo_q[W-2:0], ge};
    end
    if (fix_i) begin
      res_q <= neg_q ? word_t'(-qsat) : word_t'(qsat);
    end
  end

  assign quot_o = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rbst_datapath.sv
// Datapath: held axis word, interval state, two divider lanes and the result register.
`timescale 1ns / 1ps
`default_nettype none
module rbst_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbst_pkg::ctl_t ctl_i,
  output rbst_pkg::stat_t stat_o,
  rbst_in_if.sink        item_i,
  rbst_out_if.source     result_o
);
  import rbst_pkg::*;

  logic  first_q, last_q;
  word_t org_q, dir_q, lo_q, hi_q, ts_q, te_q;
  word_t il_q, ih_q;
  logic  missed_q;
  word_t tmin_q, tmax_q;
  logic  out_valid_q, hit_q;

  word_t t0, t1;
  logic  fire;
  logic  out_busy;
  logic  dir_zero;

  assign item_i.ready = ctl_i.in_ready;
  assign fire         = item_i.valid & ctl_i.in_ready;
  assign dir_zero     = (dir_q == '0);
  assign out_busy     = out_valid_q & ~result_o.ready;

  rbst_div_lane u_lane_low (
    .clk_i    (clk_i),
    .init_i   (ctl_i.div_init),
    .pre_i    (ctl_i.div_pre),
    .step_i   (ctl_i.div_step),
    .fix_i    (ctl_i.div_fix),
    .bound_i  (lo_q),
    .origin_i (org_q),
    .dir_i    (dir_q),
    .quot_o   (t0)
  );

  rbst_div_lane u_lane_high (
    .clk_i    (clk_i),
    .init_i   (ctl_i.div_init),
    .pre_i    (ctl_i.div_pre),
    .step_i   (ctl_i.div_step),
    .fix_i    (ctl_i.div_fix),
    .bound_i  (hi_q),
    .origin_i (org_q),
    .dir_i    (dir_q),
    .quot_o   (t1)
  );

  // Hold the accepted word and order the two slab distances.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      first_q <= item_i.first_axis;
      last_q  <= item_i.last_axis;
      org_q   <= item_i.ray_origin;
      dir_q   <= item_i.ray_direction;
      lo_q    <= item_i.box_low;
      hi_q    <= item_i.box_high;
      ts_q    <= item_i.t_start;
      te_q    <= item_i.t_end;
    end
    if (ctl_i.order) begin
      tmin_q <= (t0 > t1) ? t1 : t0;
      tmax_q <= (t0 > t1) ? t0 : t1;
    end
  end

  // Interval state and miss flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      il_q     <= '0;
      ih_q     <= '0;
      missed_q <= 1'b0;
    end else begin
      if (ctl_i.first_load && first_q) begin
        il_q     <= ts_q;
        ih_q     <= te_q;
        missed_q <= 1'b0;
      end
      if (ctl_i.par_test && dir_zero && ((org_q < lo_q) || (org_q > hi_q))) begin
        missed_q <= 1'b1;
      end
      if (ctl_i.narrow) begin
        if (tmin_q > il_q) il_q <= tmin_q;
        if (tmax_q < ih_q) ih_q <= tmax_q;
      end
      if (ctl_i.empty_test && (ih_q < il_q)) begin
        missed_q <= 1'b1;
      end
    end
  end

  // Output register: load when free, drop on handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load && !out_busy) begin
      hit_q <= ~missed_q;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.hit   = hit_q;

  always_comb begin
    stat_o          = '0;
    stat_o.in_valid = item_i.valid;
    stat_o.missed   = missed_q;
    stat_o.dir_zero = dir_zero;
    stat_o.last     = last_q;
    stat_o.out_busy = out_busy;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rbst_sequencer.sv
// Microcode sequencer: program counter, loop counter and control store.
`timescale 1ns / 1ps
`default_nettype none
module rbst_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rbst_pkg::stat_t stat_i,
  output rbst_pkg::ctl_t  ctl_o
);
  import rbst_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  ucode_t           uw;
  logic             take;

  always_comb begin
    uw = ucode_rom(upc_q);
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_VALID: take = ~stat_i.in_valid;
      C_MISSED:   take = stat_i.missed;
      C_DIR_ZERO: take = stat_i.dir_zero;
      C_CNT_NZ:   take = (cnt_q != '0);
      C_NOT_LAST: take = ~stat_i.last;
      C_OUT_BUSY: take = stat_i.out_busy;
      default:    take = 1'b1;
    endcase
    upc_d = take ? uw.target : upc_q + 1'b1;
    cnt_d = cnt_q;
    if (uw.ctl.div_init) begin
      cnt_d = CNT_W'(WORD_WIDTH - 1);
    end else if (uw.ctl.div_step) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_WAIT;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o = uw.ctl;

endmodule
`default_nettype wire

FILE: hw/rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
//
//   channel    dir   handshake      word contents
//   item_i     in    valid/ready    first_axis, last_axis, ray_origin, ray_direction,
//                                   box_low, box_high, t_start, t_end (signed Q16.16)
//   result_o   out   valid/ready    hit
//
// One axis word at a time. A clipping axis runs from acceptance through load,
// skip test, parallel test, the divider loop of one quotient bit per cycle, fix,
// order, narrow and empty test, with both slab distances divided side by side in
// two lanes. A parallel axis, and one after a miss, skips the divider loop. A last
// axis then loads the hit word. Reset clears the interval to zero and the miss
// flag. A stalled result holds the sequencer in its output step.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbst_in_if.sink     item_i,
  rbst_out_if.source  result_o
);
  import rbst_pkg::*;

  ctl_t  ctl;   // control word from the microprogram
  stat_t stat;  // flags tested by conditional jumps

  // Sequencer: steps through accept, load, tests, division loop, clip, emit.
  rbst_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Datapath: holds the word, runs the two divider lanes, narrows the interval.
  rbst_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

FILE: test/ray_box_slab_test_test.sv
// Testbench for the ray/box slab test: directed and random queries checked against a local predictor.
`timescale 1ns / 1ps
module ray_box_slab_test_test;

  typedef rbst_pkg::word_t word_t;

  localparam int    W           = rbst_pkg::WORD_WIDTH;
  localparam int    ONE         = 1 << rbst_pkg::FRAC_BITS;   // 1.0 in Q16.16
  localparam word_t W_MAX       = {1'b0, {(W-1){1'b1}}};
  localparam word_t W_MIN       = {1'b1, {(W-1){1'b0}}};
  localparam int    STALL_LIMIT = 2000;   // cycles with no word moving on either side
  localparam int    TAIL_CYCLES = 60;     // clipping axis plus hit load, with margin

  // Kinds of random axis word.
  typedef enum int {
    AXIS_NEAR,      // slab close to the origin, moderate direction
    AXIS_PARALLEL,  // zero direction component
    AXIS_WIDE       // origin, direction and slab bounds drawn over their full range
  } axis_kind_e;

  // One input word as the sender sees it.
  typedef struct {
    logic  first_axis;
    logic  last_axis;
    word_t ray_origin;
    word_t ray_direction;
    word_t box_low;
    word_t box_high;
    word_t t_start;
    word_t t_end;
  } axis_t;

  logic clk_i;
  logic rst_ni;

  rbst_in_if  item_if ();
  rbst_out_if result_if ();

  ray_box_slab_test dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state: the kept parametric interval and the miss flag of the open query.
  word_t span_lo;
  word_t span_hi;
  logic  span_missed;

  // Hit flags still owed by the block, oldest first.
  logic pending_hits[$];

  bit idle_on;      // allow random gaps on both sides
  int fail_count;
  int idle_cycles;

  // Run statistics for the closing summary.
  int axes_sent;
  int results_seen;
  int hits_seen;
  int parallel_axes;
  int saturated_dists;
  int noise_words;

  // Slab distance ((bound - origin) << FRAC_BITS) / direction: exact difference,
  // truncation toward zero, then saturation to the word range. Direction is non-zero.
  function automatic word_t slab_distance(word_t bound, word_t origin, word_t dir);
    longint diff;
    longint num_mag;
    longint den_mag;
    longint quot;
    longint cap;
    logic   neg;
    diff    = longint'(bound) - longint'(origin);
    neg     = (diff < 0) != (dir < 0);
    num_mag = (diff < 0 ? -diff : diff) <<< rbst_pkg::FRAC_BITS;
    den_mag = (dir < 0) ? -longint'(dir) : longint'(dir);
    quot    = num_mag / den_mag;
    cap     = neg ? (longint'(1) <<< (W-1)) : (longint'(1) <<< (W-1)) - 1;
    if (quot > cap) begin
      quot = cap;
      saturated_dists++;
    end
    return word_t'(neg ? -quot : quot);
  endfunction

  // Clip the kept interval against one axis and queue the hit flag on a last axis.
  function automatic void clip_axis(axis_t a);
    word_t t_near;
    word_t t_far;
    word_t t_swap;
    if (a.first_axis) begin
      span_lo     = a.t_start;
      span_hi     = a.t_end;
      span_missed = 1'b0;
    end
    if (!span_missed) begin
      if (a.ray_direction == 0) begin
        // parallel ray: only the origin position decides
        parallel_axes++;
        if (a.ray_origin < a.box_low || a.ray_origin > a.box_high) span_missed = 1'b1;
      end else begin
        t_near = slab_distance(a.box_low, a.ray_origin, a.ray_direction);
        t_far  = slab_distance(a.box_high, a.ray_origin, a.ray_direction);
        if (t_near > t_far) begin
          t_swap = t_near;
          t_near = t_far;
          t_far  = t_swap;
        end
        if (t_near > span_lo) span_lo = t_near;
        if (t_far < span_hi) span_hi = t_far;
        if (span_hi < span_lo) span_missed = 1'b1;
      end
    end
    if (a.last_axis) pending_hits.push_back(!span_missed);
  endfunction

  function automatic axis_t make_axis(logic first, logic last, word_t origin, word_t dir,
                                      word_t low, word_t high, word_t ts, word_t te);
    axis_t a;
    a.first_axis    = first;
    a.last_axis     = last;
    a.ray_origin    = origin;
    a.ray_direction = dir;
    a.box_low       = low;
    a.box_high      = high;
    a.t_start       = ts;
    a.t_end         = te;
    return a;
  endfunction

  // Uniform value in [-span, span].
  function automatic word_t small_word(int span);
    return word_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic axis_t random_axis(logic first, logic last);
    axis_t      a;
    axis_kind_e kind;
    word_t      swap;
    int         pick;
    pick = $urandom_range(0, 9);
    kind = (pick == 0) ? AXIS_WIDE : (pick == 1) ? AXIS_PARALLEL : AXIS_NEAR;
    a.first_axis = first;
    a.last_axis  = last;
    // interval fields count only on a first axis, so draw them wide elsewhere
    if (first && $urandom_range(0, 7) != 0) begin
      a.t_start = word_t'($urandom_range(0, ONE));
      a.t_end   = $urandom_range(0, 3) == 0 ? W_MAX : word_t'($urandom_range(0, 1 << 26));
    end else begin
      a.t_start = word_t'($urandom);
      a.t_end   = word_t'($urandom);
    end
    if (kind == AXIS_WIDE) begin
      a.ray_origin    = word_t'($urandom);
      a.ray_direction = word_t'($urandom);
      a.box_low       = word_t'($urandom);
      a.box_high      = word_t'($urandom);
    end else begin
      a.ray_origin = small_word(1 << 20);
      a.box_low    = a.ray_origin + small_word(1 << 20);
      a.box_high   = a.box_low + word_t'($urandom_range(0, 1 << 20));
      if ($urandom_range(0, 15) == 0) begin
        // inverted slab, passed through uncorrected
        swap       = a.box_low;
        a.box_low  = a.box_high;
        a.box_high = swap;
      end
      if (kind == AXIS_PARALLEL) begin
        a.ray_direction = '0;
      end else begin
        a.ray_direction = small_word(1 << 18);
        if ($urandom_range(0, 7) == 0) a.ray_direction = a.ray_direction <<< 8;
      end
    end
    return a;
  endfunction

  // Send one axis word: optional gap, then hold valid until the block takes it.
  // Valid drops at the next falling edge, before the block is ready again, so no
  // word is offered twice.
  task automatic send_axis(input axis_t a);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      // half the gaps start once ready is up, so they land in the wait step
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk_i);
        while (!item_if.ready) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid         <= 1'b1;
    item_if.first_axis    <= a.first_axis;
    item_if.last_axis     <= a.last_axis;
    item_if.ray_origin    <= a.ray_origin;
    item_if.ray_direction <= a.ray_direction;
    item_if.box_low       <= a.box_low;
    item_if.box_high      <= a.box_high;
    item_if.t_start       <= a.t_start;
    item_if.t_end         <= a.t_end;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    clip_axis(a);
    axes_sent++;
    @(negedge clk_i);
    item_if.valid <= 1'b0;
  endtask

  task automatic wait_hits_drained();
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  // Whole queries of random length with random content, plus unframed noise words.
  task automatic run_queries(input int n_axes, input bit vary_idle);
    int sent;
    int len;
    sent = 0;
    while (sent < n_axes) begin
      if (!vary_idle) idle_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) begin
        send_axis(random_axis($urandom_range(0, 1), $urandom_range(0, 1)));
        noise_words++;
        sent++;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 3;
        for (int i = 0; i < len; i++) begin
          send_axis(random_axis(i == 0, i == len - 1));
        end
        sent += len;
      end
    end
  endtask

  // Straight after reset: an axis without a first flag clips the cleared interval.
  task automatic test_reset_state();
    send_axis(make_axis(1'b0, 1'b1, 0, ONE, -ONE, ONE, 0, 0));
  endtask

  // One-axis queries: parallel inside, outside and on the bound, clipping both
  // ways, and inverted slabs.
  task automatic test_single_axis();
    send_axis(make_axis(1'b1, 1'b1, 0, 0, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, 2 * ONE, 0, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, -ONE, 0, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, 0, ONE, 2 * ONE, 3 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, 0, -ONE, 2 * ONE, 3 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, 0, ONE, 3 * ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b1, 0, 0, ONE, -ONE, 0, 10 * ONE));
  endtask

  // Three-axis queries: a clean hit, an early miss that later axes cannot undo,
  // and disjoint slab intervals.
  task automatic test_multi_axis();
    send_axis(make_axis(1'b1, 1'b0, 0, ONE, ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b0, 0, ONE, ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b1, 0, ONE, ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b0, 0, 0, ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b0, 0, ONE, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b1, 0, 0, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b1, 1'b0, 0, ONE, ONE, 2 * ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b0, 0, 0, -ONE, ONE, 0, 10 * ONE));
    send_axis(make_axis(1'b0, 1'b1, 0, ONE, 3 * ONE, 4 * ONE, 0, 10 * ONE));
  endtask

  // Field extremes: saturation both ways, the most negative direction, an empty
  // starting interval and one-point slabs at either end of the range.
  task automatic test_extremes();
    send_axis(make_axis(1'b1, 1'b1, W_MIN, 1, W_MIN, W_MAX, W_MIN, W_MAX));
    send_axis(make_axis(1'b1, 1'b1, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX));
    send_axis(make_axis(1'b1, 1'b1, W_MIN, -1, W_MAX, W_MIN, W_MAX, W_MIN));
    send_axis(make_axis(1'b1, 1'b1, W_MAX, 0, W_MAX, W_MAX, 0, 0));
    send_axis(make_axis(1'b1, 1'b1, W_MIN, 0, W_MIN, W_MIN, 0, 0));
    send_axis(make_axis(1'b1, 1'b1, 0, -1, W_MIN, W_MAX, W_MIN, W_MAX));
  endtask

  // Random queries with idling; halfway, hold the sender until every hit is back.
  task automatic test_random_queries();
    run_queries(500, 1'b1);
    wait_hits_drained();
    run_queries(500, 1'b1);
  endtask

  // Closing stretch with no gaps on either side.
  task automatic test_steady_stream();
    run_queries(150, 1'b0);
  endtask

  // Result sink: random stall bursts while idling is allowed.
  initial begin : result_stalls
    int stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left      = $urandom_range(1, 4) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted hit word with the oldest owed flag.
  always @(posedge clk_i) begin : check_results
    logic owed;
    logic exp_hit;
    if (rst_ni && result_if.valid && result_if.ready) begin
      owed    = (pending_hits.size() != 0);
      exp_hit = owed ? pending_hits.pop_front() : 1'b0;
      results_seen++;
      if (result_if.hit === 1'b1) hits_seen++;
      if (!owed || result_if.hit !== exp_hit) begin
        fail_count++;
        if (fail_count <= 10) begin
          if (!owed) begin
            $display("%0t: hit word with nothing owed, got %b", $time, result_if.hit);
          end else begin
            $display("%0t: result %0d: expected hit %b, got %b", $time, results_seen,
                     exp_hit, result_if.hit);
          end
        end
      end
    end
  end

  // Watchdog: end the run once no word has moved for too long.
  always @(posedge clk_i) begin : watchdog
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before reset lifts.
    rst_ni                = 1'b0;
    idle_on               = 1'b1;
    fail_count            = 0;
    idle_cycles           = 0;
    axes_sent             = 0;
    results_seen          = 0;
    hits_seen             = 0;
    parallel_axes         = 0;
    saturated_dists       = 0;
    noise_words           = 0;
    span_lo               = '0;
    span_hi               = '0;
    span_missed           = 1'b0;
    item_if.valid         = 1'b0;
    item_if.first_axis    = 1'b0;
    item_if.last_axis     = 1'b0;
    item_if.ray_origin    = '0;
    item_if.ray_direction = '0;
    item_if.box_low       = '0;
    item_if.box_high      = '0;
    item_if.t_start       = '0;
    item_if.t_end         = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_single_axis();
    test_multi_axis();
    test_extremes();
    test_random_queries();
    test_steady_stream();

    // Drain the owed hits, then let any late word show up.
    wait_hits_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d axis words (%0d unframed); checked %0d hit words, %0d of them hits.",
             axes_sent, noise_words, results_seen, hits_seen);
    $display("Saw %0d parallel axes and %0d saturated slab distances; %0d failures.",
             parallel_axes, saturated_dists, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
